FILE: hw/rtl/vvh_pkg.sv
// shared types and constants of the voxel value histogram
`timescale 1ns / 1ps

package vvh_pkg;

    // histogram geometry
    localparam int BIN_COUNT = 1024;
    localparam int BIN_W     = $clog2(BIN_COUNT);

    // fixed field widths
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 64;
    localparam int KIND_W = 2;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE = 1'd1;
    localparam logic [VAL_W-1:0]     MIN_VALUE_RST = 32'd0;
    localparam logic [VAL_W-1:0]     BIN_SCALE_RST = 32'd65536;

    // input word kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // job queue between front and back, depth a power of two
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_LW    = Q_AW + 1;

    // operations carried out by the back end
    typedef enum logic [1:0] {
        OP_COUNT = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_PEAK  = 2'd3
    } t_op;

    // classified job
    typedef struct packed {
        t_op              op;
        logic [BIN_W-1:0] bin;
        logic [IDX_W-1:0] idx;
        logic             clamped;
        logic             skipped;
        logic             hit;
    } t_job;

endpackage

FILE: hw/rtl/vvh_front.sv
// front end: config registers, accept, bin computation and classification
`timescale 1ns / 1ps

module vvh_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vvh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vvh_pkg::VAL_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [vvh_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [vvh_pkg::VAL_W-1:0]  i_value,
    input  logic                              i_active,
    input  logic [vvh_pkg::IDX_W-1:0]         i_read_bin,
    output logic                              o_push,
    output vvh_pkg::t_job                     o_job,
    input  logic                              i_full
);

    logic [vvh_pkg::VAL_W-1:0] r_min_value;
    logic [vvh_pkg::VAL_W-1:0] r_bin_scale;

    // stage 1: difference and magnitude
    logic                        r_s1_valid;
    logic [vvh_pkg::KIND_W-1:0]  r_s1_kind;
    logic                        r_s1_active;
    logic [vvh_pkg::IDX_W-1:0]   r_s1_read_bin;
    logic                        r_s1_neg;
    logic [vvh_pkg::VAL_W-1:0]   r_s1_mag;

    // stage 2: product
    logic                        r_s2_valid;
    logic [vvh_pkg::KIND_W-1:0]  r_s2_kind;
    logic                        r_s2_active;
    logic [vvh_pkg::IDX_W-1:0]   r_s2_read_bin;
    logic                        r_s2_neg;
    logic [2*vvh_pkg::VAL_W-1:0] r_s2_prod;

    logic                        w_accept;
    logic                        w_s1_move;
    logic [vvh_pkg::VAL_W:0]     w_diff;
    logic                        w_neg;
    logic [vvh_pkg::VAL_W:0]     w_abs;
    logic [2*vvh_pkg::VAL_W-1:0] w_prod;
    logic [vvh_pkg::VAL_W-1:0]   w_whole;
    vvh_pkg::t_job               w_job;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_value <= vvh_pkg::MIN_VALUE_RST;
            r_bin_scale <= vvh_pkg::BIN_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vvh_pkg::REG_MIN_VALUE: r_min_value <= i_cfg_data;
                vvh_pkg::REG_BIN_SCALE: r_bin_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow
    assign o_push     = r_s2_valid && !i_full;
    assign w_s1_move  = r_s1_valid && (!r_s2_valid || o_push);
    assign o_in_stall = r_s1_valid && !w_s1_move;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept || (r_s1_valid && !w_s1_move);
            r_s2_valid <= w_s1_move || (r_s2_valid && !o_push);
        end
    end

    // signed difference at 33 bits and its magnitude
    assign w_diff = {i_value[vvh_pkg::VAL_W-1], i_value}
                  - {r_min_value[vvh_pkg::VAL_W-1], r_min_value};
    assign w_neg  = w_diff[vvh_pkg::VAL_W];
    assign w_abs  = w_neg ? ((vvh_pkg::VAL_W+1)'(0) - w_diff) : w_diff;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_kind     <= i_kind;
            r_s1_active   <= i_active;
            r_s1_read_bin <= i_read_bin;
            r_s1_neg      <= w_neg;
            r_s1_mag      <= w_abs[vvh_pkg::VAL_W-1:0];
        end
    end

    // q32.32 product of magnitude and scale
    assign w_prod = r_s1_mag * r_bin_scale;

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_s2_kind     <= r_s1_kind;
            r_s2_active   <= r_s1_active;
            r_s2_read_bin <= r_s1_read_bin;
            r_s2_neg      <= r_s1_neg;
            r_s2_prod     <= w_prod;
        end
    end

    // classify into a back-end job
    assign w_whole = r_s2_prod[2*vvh_pkg::VAL_W-1:vvh_pkg::VAL_W];

    always_comb begin
        w_job         = '0;
        w_job.op      = vvh_pkg::OP_PEAK;
        case (r_s2_kind)
            vvh_pkg::KIND_SAMPLE: begin
                if (!r_s2_active) begin
                    w_job.skipped = 1'b1;
                end else begin
                    w_job.op = vvh_pkg::OP_COUNT;
                    if (r_s2_neg) begin
                        w_job.bin     = '0;
                        w_job.clamped = (w_whole != '0);
                    end else if (w_whole >= vvh_pkg::VAL_W'(vvh_pkg::BIN_COUNT)) begin
                        w_job.bin     = vvh_pkg::BIN_W'(vvh_pkg::BIN_COUNT - 1);
                        w_job.clamped = 1'b1;
                    end else begin
                        w_job.bin = vvh_pkg::BIN_W'(w_whole);
                    end
                    w_job.idx = vvh_pkg::IDX_W'(w_job.bin);
                end
            end
            vvh_pkg::KIND_READ: begin
                w_job.op  = vvh_pkg::OP_READ;
                w_job.bin = vvh_pkg::BIN_W'(r_s2_read_bin);
                w_job.idx = r_s2_read_bin;
                w_job.hit = (vvh_pkg::VAL_W'(r_s2_read_bin)
                             < vvh_pkg::VAL_W'(vvh_pkg::BIN_COUNT));
            end
            vvh_pkg::KIND_CLEAR: begin
                w_job.op = vvh_pkg::OP_CLEAR;
            end
            default: ;
        endcase
    end

    assign o_job = w_job;

endmodule

FILE: hw/rtl/vvh_queue.sv
// short job queue between front and back end
`timescale 1ns / 1ps

module vvh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vvh_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output vvh_pkg::t_job o_head,
    output logic          o_empty
);

    vvh_pkg::t_job              r_slot [vvh_pkg::Q_DEPTH];
    logic [vvh_pkg::Q_AW-1:0]   r_wr_ptr;
    logic [vvh_pkg::Q_AW-1:0]   r_rd_ptr;
    logic [vvh_pkg::Q_LW-1:0]   r_level;

    assign o_full  = (r_level == vvh_pkg::Q_LW'(vvh_pkg::Q_DEPTH));
    assign o_empty = (r_level == '0);
    assign o_head  = r_slot[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (!i_push && i_pop) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: hw/rtl/vvh_back.sv
// back end: counter memory, update, clearing pass and result register
`timescale 1ns / 1ps

module vvh_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  vvh_pkg::t_job                 i_head,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [vvh_pkg::IDX_W-1:0]     o_bin_index,
    output logic                          o_clamped,
    output logic                          o_skipped,
    output logic [vvh_pkg::CNT_W-1:0]     o_bin_count,
    output logic [vvh_pkg::CNT_W-1:0]     o_peak_count
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_WIPE  = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [vvh_pkg::BIN_W-1:0]   r_wipe_addr, n_wipe_addr;
    logic                        r_wipe_reply, n_wipe_reply;
    logic [vvh_pkg::CNT_W-1:0]   r_peak, n_peak;
    logic                        r_out_valid, n_out_valid;
    vvh_pkg::t_job               r_cur;

    logic [vvh_pkg::CNT_W-1:0]   r_mem [vvh_pkg::BIN_COUNT];
    logic [vvh_pkg::CNT_W-1:0]   r_rd_data;

    logic [vvh_pkg::IDX_W-1:0]   r_bin_index, n_bin_index;
    logic                        r_clamped, n_clamped;
    logic                        r_skipped, n_skipped;
    logic [vvh_pkg::CNT_W-1:0]   r_bin_count, n_bin_count;
    logic [vvh_pkg::CNT_W-1:0]   r_peak_count, n_peak_count;

    logic                        w_out_free;
    logic                        w_load;
    logic [vvh_pkg::CNT_W-1:0]   w_inc;
    logic [vvh_pkg::CNT_W-1:0]   w_top_peak;
    logic                        w_mem_we;
    logic [vvh_pkg::BIN_W-1:0]   w_mem_addr;
    logic [vvh_pkg::CNT_W-1:0]   w_mem_data;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = (r_state == ST_IDLE) && !i_empty;

    // saturating increment and new maximum
    assign w_inc      = (r_rd_data == '1) ? r_rd_data : r_rd_data + 1'b1;
    assign w_top_peak = (w_inc > r_peak) ? w_inc : r_peak;

    // counter memory port selection
    assign w_mem_we   = (r_state == ST_WIPE)
                     || ((r_state == ST_FETCH) && w_out_free
                         && (r_cur.op == vvh_pkg::OP_COUNT));
    assign w_mem_addr = (r_state == ST_WIPE) ? r_wipe_addr : r_cur.bin;
    assign w_mem_data = (r_state == ST_WIPE) ? '0 : w_inc;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_data;
        end
        if (o_pop) begin
            r_rd_data <= r_mem[i_head.bin];
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_wipe_addr  = r_wipe_addr;
        n_wipe_reply = r_wipe_reply;
        n_peak       = r_peak;
        w_load       = 1'b0;
        n_bin_index  = r_cur.idx;
        n_clamped    = r_cur.clamped;
        n_skipped    = r_cur.skipped;
        n_bin_count  = '0;
        n_peak_count = r_peak;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    case (i_head.op)
                        vvh_pkg::OP_COUNT, vvh_pkg::OP_READ: begin
                            n_state = ST_FETCH;
                        end
                        vvh_pkg::OP_CLEAR: begin
                            n_state      = ST_WIPE;
                            n_wipe_addr  = '0;
                            n_wipe_reply = 1'b1;
                            n_peak       = '0;
                        end
                        default: begin
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                    if (r_cur.op == vvh_pkg::OP_COUNT) begin
                        n_bin_count  = w_inc;
                        n_peak       = w_top_peak;
                        n_peak_count = w_top_peak;
                    end else if (r_cur.hit) begin
                        n_bin_count = r_rd_data;
                    end
                end
            end
            ST_WIPE: begin
                n_wipe_addr = r_wipe_addr + 1'b1;
                if (r_wipe_addr == vvh_pkg::BIN_W'(vvh_pkg::BIN_COUNT - 1)) begin
                    n_state      = r_wipe_reply ? ST_EMIT : ST_IDLE;
                    n_wipe_reply = 1'b0;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = w_load || (r_out_valid && i_out_stall);
    end

    // control state, reset starts a clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_WIPE;
            r_wipe_addr  <= '0;
            r_wipe_reply <= 1'b0;
            r_peak       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wipe_addr  <= n_wipe_addr;
            r_wipe_reply <= n_wipe_reply;
            r_peak       <= n_peak;
            r_out_valid  <= n_out_valid;
        end
    end

    // current job and result word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        if (w_load) begin
            r_bin_index  <= n_bin_index;
            r_clamped    <= n_clamped;
            r_skipped    <= n_skipped;
            r_bin_count  <= n_bin_count;
            r_peak_count <= n_peak_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_bin_index  = r_bin_index;
    assign o_clamped    = r_clamped;
    assign o_skipped    = r_skipped;
    assign o_bin_count  = r_bin_count;
    assign o_peak_count = r_peak_count;

endmodule

FILE: hw/rtl/voxel_value_histogram.sv
// top level of the voxel value histogram
//
//   channel   direction  handshake                 payload
//   in        into       i_in_valid / o_in_stall   i_kind i_value i_active i_read_bin
//   out       out of     o_out_valid / i_out_stall o_bin_index o_clamped o_skipped
//                                                  o_bin_count o_peak_count
//   cfg       into       i_cfg_we                  i_cfg_index i_cfg_data
//
// a word passes two front stages (difference, multiply) into a 4-deep queue
// sample words pass the back end as a counter read, then a write; read words only read
// a clear word walks the counter memory one entry a cycle, then emits its result
// after reset the same clearing pass runs before the first word is served
// the front keeps accepting while the queue has room, the back waits only on the output
`timescale 1ns / 1ps

module voxel_value_histogram (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vvh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vvh_pkg::VAL_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [vvh_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [vvh_pkg::VAL_W-1:0]  i_value,
    input  logic                              i_active,
    input  logic [vvh_pkg::IDX_W-1:0]         i_read_bin,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [vvh_pkg::IDX_W-1:0]         o_bin_index,
    output logic                              o_clamped,
    output logic                              o_skipped,
    output logic [vvh_pkg::CNT_W-1:0]         o_bin_count,
    output logic [vvh_pkg::CNT_W-1:0]         o_peak_count
);

    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;
    vvh_pkg::t_job w_job;
    vvh_pkg::t_job w_head;

    // accept and classify
    vvh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .i_active    (i_active),
        .i_read_bin  (i_read_bin),
        .o_push      (w_push),
        .o_job       (w_job),
        .i_full      (w_full)
    );

    // decoupling queue
    vvh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    // counters and results
    vvh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_bin_index  (o_bin_index),
        .o_clamped    (o_clamped),
        .o_skipped    (o_skipped),
        .o_bin_count  (o_bin_count),
        .o_peak_count (o_peak_count)
    );

    // no counter exceeds the running maximum
    a_peak_covers_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_peak_count >= o_bin_count))
        else $error("bin count above running maximum");

    // a skipped sample carries no bin, no count and no clamp
    a_skip_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_skipped) |->
            ((o_bin_count == '0) && (o_bin_index == '0) && !o_clamped))
        else $error("skipped sample with bin data");

    // clamping only lands on an end bin
    a_clamp_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clamped) |->
            ((o_bin_index == '0)
             || (o_bin_index == vvh_pkg::IDX_W'(vvh_pkg::BIN_COUNT - 1))))
        else $error("clamped sample not in an end bin");

    // queue never takes a job when full nor gives one when empty
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full) && !(w_pop && w_empty))
        else $error("job queue overrun or underrun");

endmodule
